// ===== sv/ddo_pkg.sv =====
package ddo_pkg;

    // Multiplier request: operands are signed, the product is rounded half
    // away from zero after a right shift of 31 (sh31 high) or 16 (sh31 low).
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [33:0] b;
        logic               sh31;
    } mul_req_t;

    // Divider request: rounded quotient of num by a nonzero heading step.
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [15:0] den;
    } div_req_t;

    // Sine and cosine request for one binary angle.
    typedef struct packed {
        logic               start;
        logic signed [15:0] angle;
    } cor_req_t;

    localparam logic [31:0]        COUNT_SCALE_RESET = 32'd7360950;
    localparam logic signed [32:0] CORDIC_GAIN       = 33'sd652032874;
    localparam logic signed [33:0] KPI               = 34'sd683565276;
    localparam logic signed [47:0] Q48_MAX           = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q48_MIN           = 48'sh8000_0000_0000;
    localparam logic signed [49:0] STEP_LIM          = 50'sh1_0000_0000_0000;

    // Arctangent of 2^-i in units where 2^31 equals pi.
    function automatic logic [31:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41721;
            5'd15:   v = 32'd20860;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2607;
            5'd19:   v = 32'd1303;
            5'd20:   v = 32'd651;
            5'd21:   v = 32'd325;
            5'd22:   v = 32'd162;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd40;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd2;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Limits one position step to plus or minus 2^48.
    function automatic logic signed [49:0] clamp_step(input logic signed [63:0] v);
        logic signed [49:0] r;
        if (v > 64'(STEP_LIM))
            r = STEP_LIM;
        else if (v < -64'(STEP_LIM))
            r = -STEP_LIM;
        else
            r = v[49:0];
        return r;
    endfunction

    // Saturates to the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v > 51'(Q48_MAX))
            r = Q48_MAX;
        else if (v < 51'(Q48_MIN))
            r = Q48_MIN;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

// ===== sv/ddo_mul.sv =====
module ddo_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::mul_req_t  req,
    output logic               done,
    output logic signed [63:0] res
);

    typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_t;

    mstate_t            state_reg;
    logic [63:0]        a_mag_reg;
    logic [31:0]        b_mag_reg;
    logic               neg_reg;
    logic               sh31_reg;
    logic [95:0]        acc_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;

    logic [63:0] a_mag;
    logic [33:0] b_mag;
    logic [96:0] rnd;
    logic [96:0] quo;
    logic [62:0] m;

    always_comb
    begin
        a_mag = req.a[63] ? 64'(-req.a) : 64'(req.a);
        b_mag = req.b[33] ? 34'(-req.b) : 34'(req.b);
        rnd   = {1'b0, acc_reg} + (sh31_reg ? (97'd1 << 30) : (97'd1 << 15));
        quo   = sh31_reg ? (rnd >> 31) : (rnd >> 16);
        m     = (|quo[96:63]) ? {63{1'b1}} : quo[62:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start) begin
                        a_mag_reg <= a_mag;
                        b_mag_reg <= b_mag[31:0];
                        neg_reg   <= req.a[63] ^ req.b[33];
                        sh31_reg  <= req.sh31;
                        state_reg <= M_LO;
                    end
                end
                M_LO:
                begin
                    acc_reg   <= {16'd0, 80'(a_mag_reg) * 80'(b_mag_reg[15:0])};
                    state_reg <= M_HI;
                end
                M_HI:
                begin
                    acc_reg   <= acc_reg + {80'(a_mag_reg) * 80'(b_mag_reg[31:16]), 16'd0};
                    state_reg <= M_FIN;
                end
                M_FIN:
                begin
                    res_reg   <= neg_reg ? -$signed({1'b0, m}) : $signed({1'b0, m});
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== sv/ddo_div.sv =====
module ddo_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::div_req_t  req,
    output logic               done,
    output logic signed [63:0] res
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t            state_reg;
    logic [63:0]        n_reg;
    logic [63:0]        q_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        d_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic signed [63:0] res_reg;

    logic [63:0] n_mag;
    logic [16:0] d_mag;
    logic [16:0] rem_sh;
    logic        fits;
    logic [16:0] rem_sub;
    logic [63:0] q_new;

    always_comb
    begin
        n_mag   = req.num[63] ? 64'(-req.num) : 64'(req.num);
        d_mag   = req.den[15] ? 17'(-17'(req.den)) : 17'(req.den);
        rem_sh  = {rem_reg, n_reg[63]};
        fits    = rem_sh >= {1'b0, d_reg};
        rem_sub = rem_sh - {1'b0, d_reg};
        q_new   = {q_reg[62:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start) begin
                        n_reg     <= n_mag + 64'(d_mag[16:1]);
                        d_reg     <= d_mag[15:0];
                        neg_reg   <= req.num[63] ^ req.den[15];
                        rem_reg   <= 16'd0;
                        q_reg     <= 64'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    n_reg   <= {n_reg[62:0], 1'b0};
                    rem_reg <= fits ? rem_sub[15:0] : rem_sh[15:0];
                    q_reg   <= q_new;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        res_reg   <= neg_reg ? -$signed(q_new) : $signed(q_new);
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== sv/ddo_cordic.sv =====
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::cor_req_t  req,
    output logic               done,
    output logic signed [32:0] sin_val,
    output logic signed [32:0] cos_val
);

    localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t            state_reg;
    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [CW-1:0]      cnt_reg;
    logic               done_reg;
    logic signed [32:0] sin_reg;
    logic signed [32:0] cos_reg;

    logic signed [33:0] z0;
    logic signed [33:0] z_init;
    logic               flip_init;
    logic signed [32:0] xs;
    logic signed [32:0] ys;
    logic signed [32:0] x_new;
    logic signed [32:0] y_new;
    logic signed [33:0] z_new;
    logic signed [33:0] ang;

    always_comb
    begin
        z0 = {{2{req.angle[15]}}, req.angle, 16'd0};
        if (z0 > 34'sd1073741824) begin
            z_init    = z0 - 34'sd2147483648;
            flip_init = 1'b1;
        end else if (z0 < -34'sd1073741824) begin
            z_init    = z0 + 34'sd2147483648;
            flip_init = 1'b1;
        end else begin
            z_init    = z0;
            flip_init = 1'b0;
        end
        xs  = x_reg >>> cnt_reg;
        ys  = y_reg >>> cnt_reg;
        ang = $signed({2'b00, ddo_pkg::atan_at(5'(cnt_reg))});
        if (!z_reg[33]) begin
            x_new = x_reg - ys;
            y_new = y_reg + xs;
            z_new = z_reg - ang;
        end else begin
            x_new = x_reg + ys;
            y_new = y_reg - xs;
            z_new = z_reg + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start) begin
                        x_reg     <= ddo_pkg::CORDIC_GAIN;
                        y_reg     <= 33'sd0;
                        z_reg     <= z_init;
                        flip_reg  <= flip_init;
                        cnt_reg   <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    x_reg   <= x_new;
                    y_reg   <= y_new;
                    z_reg   <= z_new;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(STEPS - 1)) begin
                        cos_reg   <= flip_reg ? -x_new : x_new;
                        sin_reg   <= flip_reg ? -y_new : y_new;
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// ===== sv/diff_drive_odometry_integrator_core.sv =====
// Differential-drive dead-reckoning odometry integrator.
// Input channel (in_valid/in_ready): one request carries kind, left_count,
// right_count and heading. kind high clears the position; kind low is an
// encoder sample whose counts are scaled by count_scale to wheel travel.
// Output channel (out_valid/out_ready): one pose request per input request,
// pos_forward and pos_left in signed Q32.16 centimeters.
// Configuration: count_scale is written whenever cfg_we is high; the user
// must write it only while the block is idle, as the block does not enforce it.
// A clear goes straight to the emit step. A sample takes two travel
// products from the shared multiplier; the first sample then commits. A
// straight move adds a CORDIC pass on the old heading and two products; an
// arc adds CORDIC passes on both headings and, per axis, two products and a
// quotient from the radix-2 divider, which is thus used twice. in_ready is
// low while a request is in work, so a new request is not accepted until
// the previous one is through.
// Reset clears the pose and previous travel, sets the first-sample flag and
// loads the default count_scale. The output register holds a pose until it
// is taken; a new request is accepted meanwhile, but its result waits until
// the receiver takes the previous one.
module diff_drive_odometry_integrator_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] left_count,
    input  logic signed [31:0] right_count,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] pos_forward,
    output logic signed [47:0] pos_left
);

    typedef enum logic [3:0] {
        S_IDLE, S_TL, S_TR, S_CP, S_CH, S_M1, S_M2, S_DV, S_MOVE, S_COMMIT, S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic signed [47:0] pos_x_reg, pos_x_next;
    logic signed [47:0] pos_y_reg, pos_y_next;
    logic signed [47:0] prev_l_reg, prev_l_next;
    logic signed [47:0] prev_r_reg, prev_r_next;
    logic signed [15:0] prev_h_reg, prev_h_next;
    logic               first_reg, first_next;
    logic [31:0]        scale_reg, scale_next;
    logic signed [31:0] rc_reg, rc_next;
    logic signed [15:0] h_reg, h_next;
    logic signed [47:0] tl_reg, tl_next;
    logic signed [47:0] tr_reg, tr_next;
    logic signed [49:0] d_reg, d_next;
    logic signed [32:0] sp_reg, sp_next;
    logic signed [32:0] cp_reg, cp_next;
    logic signed [32:0] sh_reg, sh_next;
    logic               straight_reg, straight_next;
    logic               pass_reg, pass_next;
    logic signed [63:0] dx_reg, dx_next;
    logic signed [63:0] dy_reg, dy_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [47:0] fwd_reg, fwd_next;
    logic signed [47:0] left_reg, left_next;

    ddo_pkg::mul_req_t  mul_req;
    ddo_pkg::div_req_t  div_req;
    ddo_pkg::cor_req_t  cor_req;
    logic               mul_done, div_done, cor_done;
    logic signed [63:0] mul_res, div_res;
    logic signed [32:0] cor_sin, cor_cos;
    logic signed [49:0] d_calc;
    logic signed [15:0] dh;

    ddo_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .done (mul_done),
        .res  (mul_res)
    );

    ddo_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .done (div_done),
        .res  (div_res)
    );

    ddo_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (cor_req),
        .done   (cor_done),
        .sin_val(cor_sin),
        .cos_val(cor_cos)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        prev_h_next    = prev_h_reg;
        first_next     = first_reg;
        scale_next     = cfg_we ? cfg_wdata : scale_reg;
        rc_next        = rc_reg;
        h_next         = h_reg;
        tl_next        = tl_reg;
        tr_next        = tr_reg;
        d_next         = d_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        sh_next        = sh_reg;
        straight_next  = straight_reg;
        pass_next      = pass_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        fwd_next       = fwd_reg;
        left_next      = left_reg;

        mul_req = '0;
        div_req = '0;
        cor_req = '0;

        // Change of summed travel since the previous sample.
        d_calc = (50'(mul_res) - 50'(prev_r_reg)) + (50'(tl_reg) - 50'(prev_l_reg));
        // Heading step wraps in 16 bits into minus pi up to just under pi.
        dh     = h_reg - prev_h_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    rc_next = right_count;
                    h_next  = heading;
                    if (kind) begin
                        pos_x_next = '0;
                        pos_y_next = '0;
                        state_next = S_EMIT;
                    end else begin
                        // Travel is the negated count times the scale.
                        mul_req.start = 1'b1;
                        mul_req.a     = -64'(left_count);
                        mul_req.b     = $signed({2'b00, scale_reg});
                        state_next    = S_TL;
                    end
                end
            end
            S_TL:
            begin
                if (mul_done) begin
                    tl_next       = mul_res[47:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = -64'(rc_reg);
                    mul_req.b     = $signed({2'b00, scale_reg});
                    state_next    = S_TR;
                end
            end
            S_TR:
            begin
                if (mul_done) begin
                    tr_next = mul_res[47:0];
                    d_next  = d_calc;
                    if (first_reg) begin
                        state_next = S_COMMIT;
                    end else begin
                        cor_req.start = 1'b1;
                        cor_req.angle = prev_h_reg;
                        state_next    = S_CP;
                    end
                end
            end
            S_CP:
            begin
                if (cor_done) begin
                    sp_next   = cor_sin;
                    cp_next   = cor_cos;
                    pass_next = 1'b0;
                    if (h_reg == prev_h_reg) begin
                        // Unchanged heading: straight move along the old heading.
                        straight_next = 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = 64'(d_reg);
                        mul_req.b     = 34'(cor_sin);
                        mul_req.sh31  = 1'b1;
                        state_next    = S_M1;
                    end else begin
                        straight_next = 1'b0;
                        cor_req.start = 1'b1;
                        cor_req.angle = h_reg;
                        state_next    = S_CH;
                    end
                end
            end
            S_CH:
            begin
                if (cor_done) begin
                    sh_next       = cor_sin;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(d_reg);
                    mul_req.b     = 34'(cor_cos) - 34'(cp_reg);
                    mul_req.sh31  = 1'b1;
                    state_next    = S_M1;
                end
            end
            S_M1:
            begin
                if (mul_done) begin
                    if (straight_reg) begin
                        if (!pass_reg) begin
                            dx_next       = -mul_res;
                            pass_next     = 1'b1;
                            mul_req.start = 1'b1;
                            mul_req.a     = 64'(d_reg);
                            mul_req.b     = 34'(cp_reg);
                            mul_req.sh31  = 1'b1;
                        end else begin
                            dy_next    = mul_res;
                            state_next = S_MOVE;
                        end
                    end else begin
                        // Scale by 32768/pi so the heading step divides in
                        // binary-angle units.
                        mul_req.start = 1'b1;
                        mul_req.a     = mul_res;
                        mul_req.b     = ddo_pkg::KPI;
                        state_next    = S_M2;
                    end
                end
            end
            S_M2:
            begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = mul_res;
                    div_req.den   = dh;
                    state_next    = S_DV;
                end
            end
            S_DV:
            begin
                if (div_done) begin
                    if (!pass_reg) begin
                        dx_next       = div_res;
                        pass_next     = 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = 64'(d_reg);
                        mul_req.b     = 34'(sh_reg) - 34'(sp_reg);
                        mul_req.sh31  = 1'b1;
                        state_next    = S_M1;
                    end else begin
                        dy_next    = div_res;
                        state_next = S_MOVE;
                    end
                end
            end
            S_MOVE:
            begin
                pos_x_next = ddo_pkg::sat48(51'(pos_x_reg)
                                            + 51'(ddo_pkg::clamp_step(dx_reg)));
                pos_y_next = ddo_pkg::sat48(51'(pos_y_reg)
                                            + 51'(ddo_pkg::clamp_step(dy_reg)));
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                prev_l_next = tl_reg;
                prev_r_next = tr_reg;
                prev_h_next = h_reg;
                first_next  = 1'b0;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready) begin
                    fwd_next       = pos_y_reg;
                    left_next      = ddo_pkg::sat48(-51'(pos_x_reg));
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            prev_h_reg    <= '0;
            first_reg     <= 1'b1;
            scale_reg     <= ddo_pkg::COUNT_SCALE_RESET;
            out_valid_reg <= 1'b0;
            straight_reg  <= 1'b0;
            pass_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            prev_l_reg    <= prev_l_next;
            prev_r_reg    <= prev_r_next;
            prev_h_reg    <= prev_h_next;
            first_reg     <= first_next;
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
            straight_reg  <= straight_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg   <= rc_next;
        h_reg    <= h_next;
        tl_reg   <= tl_next;
        tr_reg   <= tr_next;
        d_reg    <= d_next;
        sp_reg   <= sp_next;
        cp_reg   <= cp_next;
        sh_reg   <= sh_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        fwd_reg  <= fwd_next;
        left_reg <= left_next;
    end

    assign out_valid   = out_valid_reg;
    assign pos_forward = fwd_reg;
    assign pos_left    = left_reg;

endmodule

// ===== sv/ddo_checker.sv =====
module ddo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               kind,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [47:0] pos_forward,
    input logic signed [47:0] pos_left
);

    // A pending pose request holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_forward) && $stable(pos_left))
        else $error("pose changed while stalled");

    // One request is worked on at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A clear accepted with the output free yields a zero pose, via S_EMIT and the output register.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind && (!out_valid || out_ready)
        |=> ##1 (out_valid && pos_forward == 48'sd0 && pos_left == 48'sd0))
        else $error("clear did not emit a zero pose");

    // The negated lateral position never reaches the most negative code.
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pos_left != 48'sh8000_0000_0000)
        else $error("pos_left out of range");

endmodule

bind diff_drive_odometry_integrator_core ddo_checker u_ddo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pos_forward(pos_forward),
    .pos_left   (pos_left)
);

// ===== tb/tb_diff_drive_odometry_integrator_core.sv =====
module tb_diff_drive_odometry_integrator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int KIND_SAMPLE = 0;
    localparam int KIND_CLEAR = 1;

    // One pending input request.
    typedef struct {
        logic        kind;
        logic [31:0] left;
        logic [31:0] right;
        logic [15:0] hdg;
    } sample_t;

    // One expected pose.
    typedef struct {
        logic [47:0] fwd;
        logic [47:0] lft;
    } pose_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic               kind;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] heading;
    logic               out_valid;
    logic               out_ready;
    logic signed [47:0] pos_forward;
    logic signed [47:0] pos_left;

    diff_drive_odometry_integrator_core #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .left_count(left_count), .right_count(right_count), .heading(heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .pos_forward(pos_forward), .pos_left(pos_left)
    );

    // Predictor state, kept apart from the block.
    longint    odo_x, odo_y, last_left, last_right, last_hdg;
    bit        first_pending;
    bit [31:0] scale_q32;

    sample_t pending_requests[$];
    pose_t   expected_poses[$];
    int      errors;
    int      sent_count;
    int      offered_count;
    int      pose_count;
    int      clears_sent;
    int      idle_cycles;
    bit      timed_out;
    bit      hold_receiver;
    int      gap_left;
    int      burst_left;

    localparam longint ATAN_STEP[16] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860};

    // Rounded, saturated product of two signed values after a right shift.
    function automatic longint scaled_product(longint a, longint b, int sh);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        logic [127:0] q;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ma * mb;
        q = (p + (128'd1 << (sh - 1))) >> sh;
        if (q > 128'h7FFF_FFFF_FFFF_FFFF)
            q = 128'h7FFF_FFFF_FFFF_FFFF;
        return ((a < 0) != (b < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint rounded_quotient(longint num, longint den);
        logic [63:0] mn, md, q;
        mn = num < 0 ? -num : num;
        md = den < 0 ? -den : den;
        q = (mn + md / 2) / md;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Appends a request at the tail of the pending queue.
    function automatic void queue_request(sample_t s);
        pending_requests = {pending_requests, s};
    endfunction

    // Rotation CORDIC over a binary angle, results in Q2.30.
    task automatic heading_sin_cos(input longint h, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit     turned;
        z = h * 65536;
        x = 652032874;
        y = 0;
        turned = 0;
        if (z > (longint'(1) << 30)) begin
            z -= longint'(1) << 31;
            turned = 1;
        end else if (z < -(longint'(1) << 30)) begin
            z += longint'(1) << 31;
            turned = 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= ATAN_STEP[i];
            end else begin
                x += ys;
                y -= xs;
                z += ATAN_STEP[i];
            end
        end
        c = turned ? -x : x;
        s = turned ? -y : y;
    endtask

    function automatic longint wheel_travel(logic [31:0] cnt);
        return scaled_product(-longint'($signed(cnt)), longint'(scale_q32), 16);
    endfunction

    task automatic shift_pose(input longint dx, input longint dy);
        longint lim;
        lim = longint'(1) << 48;
        odo_x = limit(odo_x + limit(dx, -lim, lim), -(longint'(1) << 47),
                      (longint'(1) << 47) - 1);
        odo_y = limit(odo_y + limit(dy, -lim, lim), -(longint'(1) << 47),
                      (longint'(1) << 47) - 1);
    endtask

    // Advances the predictor by one request and queues the expected pose.
    task automatic predict_pose(input sample_t r);
        longint tl, tr, h, d, sp, cp, sh, ch, dh;
        pose_t  p;
        if (r.kind == 1'(KIND_CLEAR)) begin
            odo_x = 0;
            odo_y = 0;
        end else begin
            tl = wheel_travel(r.left);
            tr = wheel_travel(r.right);
            h = longint'($signed(r.hdg));
            if (first_pending) begin
                first_pending = 0;
            end else begin
                d = (tl - last_left) + (tr - last_right);
                heading_sin_cos(last_hdg, sp, cp);
                if (h == last_hdg) begin
                    shift_pose(-scaled_product(d, sp, 31), scaled_product(d, cp, 31));
                end else begin
                    heading_sin_cos(h, sh, ch);
                    dh = longint'($signed(16'(h - last_hdg)));
                    shift_pose(
                        rounded_quotient(scaled_product(scaled_product(d, ch - cp, 31),
                                                        683565276, 16), dh),
                        rounded_quotient(scaled_product(scaled_product(d, sh - sp, 31),
                                                        683565276, 16), dh));
                end
            end
            last_left = tl;
            last_right = tr;
            last_hdg = h;
        end
        p.fwd = odo_y[47:0];
        p.lft = 48'(limit(-odo_x, -(longint'(1) << 47), (longint'(1) << 47) - 1));
        expected_poses = {expected_poses, p};
    endtask

    function automatic sample_t make_request(bit k, logic [31:0] l, logic [31:0] r,
                                             logic [15:0] h);
        sample_t s;
        s.kind = k;
        s.left = l;
        s.right = r;
        s.hdg = h;
        return s;
    endfunction

    // A drive segment: counts move by small random steps, the heading by small
    // turns, half turns or not at all, with an occasional clear or wild sample.
    task automatic queue_trip(input int n);
        logic [31:0] l, r;
        logic [15:0] h;
        int          pick;
        l = $urandom;
        r = $urandom;
        h = 16'($urandom);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                queue_request(make_request(1'(KIND_CLEAR), $urandom, $urandom,
                                           16'($urandom)));
            end else if (pick < 10) begin
                queue_request(make_request(1'(KIND_SAMPLE), $urandom, $urandom,
                                           16'($urandom)));
            end else begin
                l += 32'($signed($urandom_range(0, 4000)) - 2000);
                r += 32'($signed($urandom_range(0, 4000)) - 2000);
                if (pick < 45)
                    h += 16'($signed($urandom_range(0, 2000)) - 1000);
                else if (pick < 50)
                    h += 16'h8000;
                queue_request(make_request(1'(KIND_SAMPLE), l, r, h));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_poses.size() != 0 || in_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic set_scale(input logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        scale_q32 = v;
    endtask

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Driver: bursts of requests with random gaps between them. A request
    // stays on the bus until its acceptance by the block has been counted.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
            offered_count <= 0;
        end else if (in_valid && sent_count != offered_count) begin
            // Hold the request until it is taken.
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_requests.size() != 0) begin
            kind <= pending_requests[0].kind;
            left_count <= pending_requests[0].left;
            right_count <= pending_requests[0].right;
            heading <= pending_requests[0].hdg;
            in_valid <= 1'b1;
            offered_count <= offered_count + 1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= $urandom_range(0, 3) == 0 ? $urandom_range(1, 80) : 0;
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // The request leaves the queue when the block takes it.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) begin
            predict_pose(pending_requests.pop_front());
            sent_count++;
            if (kind == 1'(KIND_CLEAR))
                clears_sent++;
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_receiver)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 9) < 7) || (pose_count % 200 < 40);
    end

    // Monitor: every accepted pose is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            pose_count++;
            if (expected_poses.size() == 0) begin
                $error("pose with no request outstanding");
                errors++;
            end else begin
                if (pos_forward !== expected_poses[0].fwd) begin
                    $error("pos_forward expected %0h got %0h", expected_poses[0].fwd,
                           pos_forward);
                    errors++;
                end
                if (pos_left !== expected_poses[0].lft) begin
                    $error("pos_left expected %0h got %0h", expected_poses[0].lft, pos_left);
                    errors++;
                end
                void'(expected_poses.pop_front());
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        kind = 1'b0;
        left_count = '0;
        right_count = '0;
        heading = '0;
        hold_receiver = 1'b0;
        errors = 0;
        sent_count = 0;
        pose_count = 0;
        clears_sent = 0;
        idle_cycles = 0;
        timed_out = 0;
        odo_x = 0;
        odo_y = 0;
        last_left = 0;
        last_right = 0;
        last_hdg = 0;
        first_pending = 1;
        scale_q32 = ddo_pkg::COUNT_SCALE_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the default scale: first sample, clear, straight
        // moves, half-turn steps, heading wrap and the count extremes.
        queue_request(make_request(1'(KIND_SAMPLE), 32'd100, 32'd100, 16'd0));
        queue_request(make_request(1'(KIND_SAMPLE), 32'd700, 32'd900, 16'd0));
        queue_request(make_request(1'(KIND_SAMPLE), 32'd1500, 32'd1200, 16'h4000));
        queue_request(make_request(1'(KIND_CLEAR), '1, '1, '1));
        queue_request(make_request(1'(KIND_SAMPLE), 32'h8000_0000,
                                   32'h7FFF_FFFF, 16'hC000));
        queue_request(make_request(1'(KIND_SAMPLE), 32'h7FFF_FFFF,
                                   32'h8000_0000, 16'h4000));
        queue_request(make_request(1'(KIND_SAMPLE), 32'h8000_0000,
                                   32'h8000_0000, 16'h7FFF));
        queue_request(make_request(1'(KIND_SAMPLE), 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 16'h8000));
        queue_request(make_request(1'(KIND_SAMPLE), 32'h8000_0000,
                                   32'h8000_0000, 16'h8000));
        queue_request(make_request(1'(KIND_SAMPLE), 32'd0, 32'd0, 16'h0001));
        queue_request(make_request(1'(KIND_SAMPLE), 32'd5, 32'hFFFF_FFF0, 16'hFFFF));
        queue_request(make_request(1'(KIND_CLEAR), '0, '0, '0));
        queue_request(make_request(1'(KIND_SAMPLE), 32'd9, 32'd9, 16'hFFFF));
        wait_drained();

        // Extreme scales; the top one drives the position into saturation.
        set_scale(32'hFFFF_FFFF);
        for (int i = 0; i < 10; i++)
            queue_request(make_request(1'(KIND_SAMPLE),
                32'(i % 2 ? 32'h7FFF_FFFF : 32'h8000_0000),
                32'(i % 2 ? 32'h7FFF_FFFF : 32'h8000_0000), 16'(i < 5 ? 0 : i * 4000)));
        wait_drained();
        set_scale(32'd1);
        queue_trip(20);
        wait_drained();
        set_scale(32'd0);
        queue_trip(20);
        wait_drained();

        // Random part across several scales.
        for (int phase = 0; phase < 6; phase++) begin
            set_scale(phase == 0 ? ddo_pkg::COUNT_SCALE_RESET : $urandom);
            queue_trip(140);
            // Long receiver hold-off while the sender keeps offering.
            if (phase == 2) begin
                hold_receiver = 1'b1;
                repeat (3000) @(posedge clk);
                hold_receiver = 1'b0;
            end
            wait_drained();
            queue_trip(150);
            wait_drained();
        end

        if (expected_poses.size() != 0) begin
            $error("%0d poses never arrived", expected_poses.size());
            errors++;
        end
        $display("Ran %0d requests (%0d clears) over several count scales, %0d poses checked.",
                 sent_count, clears_sent, pose_count);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
